### design/qsd_pkg.sv
`default_nettype none

package qsd_pkg;

   // Result codes carried in the step_event field
   typedef enum logic [1:0] {
      EV_NONE = 2'd0,
      EV_CW   = 2'd1,
      EV_CCW  = 2'd2
   } step_event_type;

   // Register indexes on the csr port
   localparam logic REG_LOCKOUT_TICKS  = 1'b0;
   localparam logic REG_STEP_THRESHOLD = 1'b1;

   localparam int LOCKOUT_W   = 8;
   localparam int THRESHOLD_W = 4;
   localparam int SUM_W       = 5;

   // Live configuration handed to the decode core
   typedef struct packed {
      logic [LOCKOUT_W-1:0]   lockout_ticks;
      logic [THRESHOLD_W-1:0] step_threshold;
   } cfg_type;

   // x4 transition table, indexed by {old AB, new AB}; 0 = no move or illegal jump
   localparam logic signed [1:0] XITION_DIR [16] = '{
       2'sd0, -2'sd1,  2'sd1,  2'sd0,
       2'sd1,  2'sd0,  2'sd0, -2'sd1,
      -2'sd1,  2'sd0,  2'sd0,  2'sd1,
       2'sd0,  2'sd1, -2'sd1,  2'sd0
   };

endpackage

`default_nettype wire

### design/quadrature_step_decoder.sv
// Channel  Dir  Handshake            Payload
// req      in   req_tvalid/tready    req_tdata[7:0]: line_a, line_b
// rsp      out  rsp_tvalid/tready    rsp_tdata[7:0]: step_event
// csr      in   csr_we               csr_index, csr_wdata[7:0]
//
// One sample per clock unless stalled; its result appears in the output
// register the cycle after the transfer. The register frees on the edge it is
// taken, so a stalled result holds req_tready low only while rsp_tready is low.
// Reset clears decoder state and loads lockout_ticks = 2, step_threshold = 4.
`default_nettype none

module quadrature_step_decoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output      logic       req_tready,
   input  wire logic [7:0] req_tdata,   // [0] line_a, [1] line_b
   output      logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   output      logic [7:0] rsp_tdata,   // [1:0] step_event
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata
);

   qsd_pkg::cfg_type        cfg_ff;
   logic                    rsp_valid_ff;
   qsd_pkg::step_event_type event_ff;
   qsd_pkg::step_event_type event_in;
   logic                    req_xfer;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lockout_ticks  <= 8'd2;
         cfg_ff.step_threshold <= 4'd4;
      end else if (csr_we) begin
         unique case (csr_index)
            qsd_pkg::REG_LOCKOUT_TICKS:  cfg_ff.lockout_ticks  <= csr_wdata;
            qsd_pkg::REG_STEP_THRESHOLD: cfg_ff.step_threshold <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;

   qsd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (req_xfer),
      .line_a     (req_tdata[0]),
      .line_b     (req_tdata[1]),
      .cfg        (cfg_ff),
      .step_event (event_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         event_ff <= event_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, event_ff};

endmodule

`default_nettype wire

### design/qsd_core.sv
`default_nettype none

module qsd_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step_en,
   input  wire logic                   line_a,
   input  wire logic                   line_b,
   input  wire qsd_pkg::cfg_type       cfg,
   output qsd_pkg::step_event_type     step_event
);

   logic [1:0]                          anchor_ff, anchor_in;
   logic                                seeded_ff, seeded_in;
   logic signed [qsd_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [qsd_pkg::LOCKOUT_W-1:0]       lock_ff, lock_in;

   logic [1:0]                          pair;
   logic [qsd_pkg::LOCKOUT_W-1:0]       lock_dec;
   logic signed [1:0]                   dir;
   logic signed [qsd_pkg::SUM_W-1:0]    sum_next;
   logic signed [qsd_pkg::SUM_W:0]      sum_wide;
   logic signed [qsd_pkg::SUM_W:0]      thr_s;

   assign pair     = {line_a, line_b};
   assign lock_dec = (lock_ff != '0) ? lock_ff - 1'b1 : lock_ff;
   assign dir      = qsd_pkg::XITION_DIR[{anchor_ff, pair}];
   assign sum_next = sum_ff + qsd_pkg::SUM_W'(dir);
   assign sum_wide = {sum_next[qsd_pkg::SUM_W-1], sum_next};
   assign thr_s    = signed'({2'b00, cfg.step_threshold});

   // Next state for one sample: seed, lockout, then table decode and threshold
   always_comb begin
      anchor_in  = anchor_ff;
      seeded_in  = seeded_ff;
      sum_in     = sum_ff;
      lock_in    = lock_ff;
      step_event = qsd_pkg::EV_NONE;
      if (!seeded_ff) begin
         anchor_in = pair;
         seeded_in = 1'b1;
      end else begin
         lock_in = lock_dec;
         if (lock_dec == '0 && pair != anchor_ff) begin
            if (dir == 2'sd0) begin
               // both lines jumped: drop the partial count, keep the anchor
               sum_in = '0;
            end else begin
               anchor_in = pair;
               sum_in    = sum_next;
               if (sum_wide >= thr_s) begin
                  sum_in     = '0;
                  lock_in    = cfg.lockout_ticks;
                  step_event = qsd_pkg::EV_CW;
               end else if (sum_wide <= -thr_s) begin
                  sum_in     = '0;
                  lock_in    = cfg.lockout_ticks;
                  step_event = qsd_pkg::EV_CCW;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_ff <= '0;
         seeded_ff <= 1'b0;
         sum_ff    <= '0;
         lock_ff   <= '0;
      end else if (step_en) begin
         anchor_ff <= anchor_in;
         seeded_ff <= seeded_in;
         sum_ff    <= sum_in;
         lock_ff   <= lock_in;
      end
   end

endmodule

`default_nettype wire

### design/qsd_checker.sv
`default_nettype none

module qsd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic [7:0] req_tdata,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp payload changed under stall");

   // every accepted sample yields a result next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted sample produced no result");

   // a full, stalled output register blocks the input
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while result stalled");

   // only none, cw or ccw codes, pad bits zero
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3 && rsp_tdata[7:2] == 6'd0)
      else $error("bad step_event code");

   // a step is never reported for the first sample after reset
   a_seed: assert property (@(posedge clock)
      $fell(reset) |-> ##1 (!rsp_tvalid || rsp_tdata[1:0] == 2'd0))
      else $error("step reported on seeding sample");

endmodule

bind quadrature_step_decoder qsd_checker u_qsd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

### test/qsd_step_checker.sv
`timescale 1ns / 100ps

// Watches the sample, result and register channels of the quadrature step decoder,
// predicts each step event and compares it against the result stream.
module qsd_step_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic       req_tready,
   input  wire logic [7:0] req_tdata,   // [0] line_a, [1] line_b
   input  wire logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire logic [7:0] rsp_tdata,   // [1:0] step_event
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata,
   output int              mismatches,
   output int              pending
);

   // predictor state
   qsd_pkg::cfg_type        live_cfg;
   logic [1:0]              anchor;
   logic                    primed;
   int                      tally;
   logic [7:0]              lockout_left;

   qsd_pkg::step_event_type expected_steps [$];
   qsd_pkg::step_event_type want;

   task automatic report_mismatch(input string what, input int got, input int exp_val);
      $display("%0t mismatch: %s (got %0d, want %0d)", $time, what, got, exp_val);
      mismatches++;
   endtask

   // position of an AB pair along the clockwise Gray cycle 00 -> 10 -> 11 -> 01
   function automatic int gray_pos(input logic [1:0] ab);
      case (ab)
         2'b00:   return 0;
         2'b10:   return 1;
         2'b11:   return 2;
         default: return 3;
      endcase
   endfunction

   // one scan tick of the decoder; updates the predictor state
   function automatic qsd_pkg::step_event_type decode_tick(input logic [1:0] ab);
      int diff;
      int thr;
      diff = 0;
      thr  = int'(live_cfg.step_threshold);
      if (!primed) begin
         anchor = ab;
         primed = 1'b1;
         return qsd_pkg::EV_NONE;
      end
      if (lockout_left != 0) lockout_left--;
      if (lockout_left != 0) return qsd_pkg::EV_NONE;
      if (ab == anchor) return qsd_pkg::EV_NONE;
      diff = (gray_pos(ab) - gray_pos(anchor) + 4) % 4;
      // both bits flipped: drop the partial count, keep the anchor
      if (diff == 2) begin
         tally = 0;
         return qsd_pkg::EV_NONE;
      end
      tally  = tally + ((diff == 1) ? 1 : -1);
      anchor = ab;
      if (tally >= thr) begin
         tally        = 0;
         lockout_left = live_cfg.lockout_ticks;
         return qsd_pkg::EV_CW;
      end
      if (tally <= -thr) begin
         tally        = 0;
         lockout_left = live_cfg.lockout_ticks;
         return qsd_pkg::EV_CCW;
      end
      return qsd_pkg::EV_NONE;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         live_cfg.lockout_ticks  = 8'd2;
         live_cfg.step_threshold = 4'd4;
         anchor       = 2'b00;
         primed       = 1'b0;
         tally        = 0;
         lockout_left = '0;
         mismatches   = 0;
         expected_steps.delete();
      end else begin
         // result transfer: compare against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (expected_steps.size() == 0) begin
               report_mismatch("result with nothing expected", int'(rsp_tdata), -1);
            end else begin
               want = expected_steps.pop_front();
               if (rsp_tdata[1:0] != want)
                  report_mismatch("step_event", int'(rsp_tdata[1:0]), int'(want));
               if (rsp_tdata[7:2] != '0)
                  report_mismatch("rsp_tdata padding", int'(rsp_tdata[7:2]), 0);
            end
         end
         // sample transfer: predict its result
         if (req_tvalid && req_tready)
            expected_steps.push_back(decode_tick({req_tdata[0], req_tdata[1]}));
         // register write
         if (csr_we) begin
            if (csr_index == qsd_pkg::REG_LOCKOUT_TICKS)
               live_cfg.lockout_ticks = csr_wdata;
            else
               live_cfg.step_threshold = csr_wdata[qsd_pkg::THRESHOLD_W-1:0];
         end
      end
      pending = expected_steps.size();
   end

endmodule

### test/tb_quadrature_step_decoder.sv
`timescale 1ns / 100ps

module tb_quadrature_step_decoder;

   localparam int NUM_PHASES     = 8;
   localparam int PHASE_ITEMS    = 180;
   localparam int HOLD_CYCLES    = 60;
   localparam int WATCHDOG_LIMIT = 2000;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       csr_we;
   logic       csr_index;
   logic [7:0] csr_wdata;

   int mismatches;
   int pending;

   // idle controls; written by the stimulus with nonblocking assignments
   int   req_idle_pct  = 0;
   int   rsp_stall_pct = 0;
   logic hold_req      = 1'b0;
   logic hold_seen     = 1'b0;
   int   hold_left     = 0;
   int   quiet_cycles  = 0;

   // register settings per phase: lockout ticks, raw threshold write data
   logic [7:0] phase_lockout [NUM_PHASES] =
      '{8'd0, 8'd255, 8'd1, 8'd170, 8'd0, 8'd255, 8'd3, 8'd2};
   logic [7:0] phase_thresh  [NUM_PHASES] =
      '{8'h01, 8'h0F, 8'hF0, 8'h55, 8'h0F, 8'h01, 8'h02, 8'h04};

   // seed, hold, CW step, lockout, move, illegal jump, CCW step, lockout, move, hold, jump
   logic [1:0] directed_ab [17] = '{
      2'b11, 2'b11, 2'b01, 2'b00, 2'b10, 2'b11, 2'b01, 2'b01, 2'b10,
      2'b11, 2'b10, 2'b00, 2'b01, 2'b01, 2'b00, 2'b00, 2'b11
   };

   quadrature_step_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   qsd_step_checker u_step_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // result side: long hold-off on request, otherwise random stalls
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen  <= hold_req;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // watchdog on cycles without any transfer or register write
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // AB pair at a position of the clockwise Gray cycle
   function automatic logic [1:0] gray_code(input int pos);
      case (pos)
         0:       return 2'b00;
         1:       return 2'b10;
         2:       return 2'b11;
         default: return 2'b01;
      endcase
   endfunction

   // tdata: [0] line_a, [1] line_b, unused bits above
   function automatic logic [7:0] pack_lines(input logic [1:0] ab, input logic [5:0] pad);
      return {pad, ab[0], ab[1]};
   endfunction

   // offer one sample, with random idle cycles ahead of it, until it is taken
   task automatic send_tick(input logic [7:0] data);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(input logic idx, input logic [7:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // wait until every predicted result has been transferred
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   initial begin
      int         walk_pos;
      int         walk_dir;
      int         roll;
      int         mode;
      logic [7:0] thr_data;

      walk_pos   = 0;
      walk_dir   = 1;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = qsd_pkg::REG_LOCKOUT_TICKS;
      csr_wdata  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed sequence at the reset settings
      for (int i = 0; i < 17; i++)
         send_tick(pack_lines(directed_ab[i], i[0] ? 6'h3F : 6'h00));

      // random phases over several register settings and idle patterns
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drained();
         thr_data = phase_thresh[ph];
         if (ph == 6) thr_data = 8'($urandom_range(0, 255));
         write_reg(qsd_pkg::REG_LOCKOUT_TICKS, phase_lockout[ph]);
         write_reg(qsd_pkg::REG_STEP_THRESHOLD, thr_data);
         csr_we <= 1'b0;

         mode = ph % 4;
         req_idle_pct  <= (mode == 1) ? 73 : (mode == 3) ? 23 : 0;
         rsp_stall_pct <= (mode == 2) ? 73 : (mode == 3) ? 23 : 0;
         // back up the block with a long receiver hold-off
         if (mode == 0) hold_req <= ~hold_req;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 5) walk_dir = -walk_dir;
            if (roll < 60)       walk_pos = walk_pos + walk_dir;
            else if (roll < 70)  walk_pos = walk_pos - walk_dir;
            else if (roll >= 88) walk_pos = $urandom_range(0, 3);
            else if (roll >= 82) walk_pos = walk_pos + 2;
            walk_pos = (walk_pos + 4) % 4;
            send_tick(pack_lines(gray_code(walk_pos), 6'($urandom)));
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
